// ===== hdl/mse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIPS subset execute - shared package
// Operation codes, syscall codes, widths and the item and result records that
// pass between the execute stage and its arithmetic unit.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Register file geometry and data width.
  localparam int NUM_REGS = 32;
  localparam int REG_AW   = 5;
  localparam int DATA_W   = 32;

  // Program counter width; results wrap at this many bits.
  localparam int          PC_WIDTH = 16;
  localparam logic [15:0] PC_MASK  = 16'((64'd1 << PC_WIDTH) - 64'd1);

  // Operation codes.
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_SLT     = 4'd2;
  localparam logic [3:0] OP_MUL     = 4'd3;
  localparam logic [3:0] OP_BEQ     = 4'd4;
  localparam logic [3:0] OP_BNE     = 4'd5;
  localparam logic [3:0] OP_ADDI    = 4'd6;
  localparam logic [3:0] OP_ORI     = 4'd7;
  localparam logic [3:0] OP_LUI     = 4'd8;
  localparam logic [3:0] OP_SYSCALL = 4'd9;

  // Registers read by a syscall: call number and argument.
  localparam logic [REG_AW-1:0] REG_V0 = 5'd2;
  localparam logic [REG_AW-1:0] REG_A0 = 5'd4;

  // Syscall numbers held in the call number register.
  localparam logic [DATA_W-1:0] CALL_PRINT_INT  = 32'd1;
  localparam logic [DATA_W-1:0] CALL_EXIT       = 32'd10;
  localparam logic [DATA_W-1:0] CALL_PRINT_CHAR = 32'd11;

  // Reported syscall actions.
  localparam logic [2:0] SYS_NONE       = 3'd0;
  localparam logic [2:0] SYS_PRINT_INT  = 3'd1;
  localparam logic [2:0] SYS_PRINT_CHAR = 3'd2;
  localparam logic [2:0] SYS_EXIT       = 3'd3;
  localparam logic [2:0] SYS_UNKNOWN    = 3'd4;

  // Decoded instruction fields held while the operands are read.
  typedef struct packed {
    logic [3:0]        op;
    logic [REG_AW-1:0] dest;
    logic [15:0]       imm;
    logic [15:0]       pc;
  } item_t;

  // Everything one instruction produces.
  typedef struct packed {
    logic              reg_written;
    logic [REG_AW-1:0] windex;
    logic [DATA_W-1:0] wvalue;
    logic              taken;
    logic [15:0]       npc;
    logic [2:0]        sys_action;
    logic [DATA_W-1:0] sys_value;
    logic              stop;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/mse_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIPS subset execute - register file
// 32 x 32-bit synchronous memory with two registered read ports and one
// write port. Per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module mse_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [mse_pkg::REG_AW-1:0] rd_addr_a,
  input  wire logic [mse_pkg::REG_AW-1:0] rd_addr_b,
  output logic      [mse_pkg::DATA_W-1:0] rd_data_a,
  output logic      [mse_pkg::DATA_W-1:0] rd_data_b,
  input  wire logic                       wr_en,
  input  wire logic [mse_pkg::REG_AW-1:0] wr_addr,
  input  wire logic [mse_pkg::DATA_W-1:0] wr_data
);
  import mse_pkg::*;

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  logic [DATA_W-1:0]   mem_a;
  logic [DATA_W-1:0]   mem_b;
  logic                hit_a;
  logic                hit_b;

  // Write port. The array itself has no reset; the valid bits stand in for it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read ports. A read in the cycle of a write to
  // the same entry returns the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_a <= mem[rd_addr_a];
      mem_b <= mem[rd_addr_b];
      hit_a <= valid[rd_addr_a] && (rd_addr_a != '0);
      hit_b <= valid[rd_addr_b] && (rd_addr_b != '0);
    end
  end

  // Register zero and never-written entries read as zero.
  assign rd_data_a = hit_a ? mem_a : '0;
  assign rd_data_b = hit_b ? mem_b : '0;

endmodule
`default_nettype wire

// ===== hdl/mse_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIPS subset execute - arithmetic unit
// Computes the register write, branch outcome, next PC and syscall report of
// one instruction from its fields and its two operand values.
// ----------------------------------------------------------------------------
module mse_alu (
  input  wire mse_pkg::item_t               item,
  input  wire logic [mse_pkg::DATA_W-1:0]   opa,
  input  wire logic [mse_pkg::DATA_W-1:0]   opb,
  output mse_pkg::result_t                  res
);
  import mse_pkg::*;

  logic [DATA_W-1:0] imm_sext;
  logic [DATA_W-1:0] imm_zext;
  logic [DATA_W-1:0] product;
  logic [DATA_W-1:0] value;
  logic              write;
  logic              taken;
  logic [15:0]       pc_m;
  logic [2:0]        act;
  logic [DATA_W-1:0] sval;
  logic              stop;

  assign imm_sext = {{16{item.imm[15]}}, item.imm};
  assign imm_zext = {16'd0, item.imm};
  assign product  = opa * opb;
  assign pc_m     = item.pc & PC_MASK;

  // Operation select.
  always_comb begin
    write = 1'b0;
    value = '0;
    taken = 1'b0;
    unique case (item.op)
      OP_ADD:  begin write = 1'b1; value = opa + opb; end
      OP_SUB:  begin write = 1'b1; value = opa - opb; end
      OP_SLT:  begin write = 1'b1; value = {31'd0, $signed(opa) < $signed(opb)}; end
      OP_MUL:  begin write = 1'b1; value = product; end
      OP_BEQ:  taken = (opa == opb);
      OP_BNE:  taken = (opa != opb);
      OP_ADDI: begin write = 1'b1; value = opa + imm_sext; end
      OP_ORI:  begin write = 1'b1; value = opa | imm_zext; end
      OP_LUI:  begin write = 1'b1; value = {item.imm, 16'd0}; end
      default: ;
    endcase
  end

  // Syscall decode: operand A carries the call number, operand B the argument.
  always_comb begin
    act  = SYS_NONE;
    sval = '0;
    stop = 1'b0;
    if (item.op == OP_SYSCALL) begin
      priority if (opa == CALL_PRINT_INT) begin
        act  = SYS_PRINT_INT;
        sval = opb;
      end else if (opa == CALL_EXIT) begin
        act  = SYS_EXIT;
        sval = opa;
        stop = 1'b1;
      end else if (opa == CALL_PRINT_CHAR) begin
        act  = SYS_PRINT_CHAR;
        sval = opb;
      end else begin
        act  = SYS_UNKNOWN;
        sval = opa;
        stop = 1'b1;
      end
    end
  end

  // Result record. A write to register zero is dropped entirely.
  always_comb begin
    res.reg_written = write && (item.dest != '0);
    res.windex      = res.reg_written ? item.dest : '0;
    res.wvalue      = res.reg_written ? value : '0;
    res.taken       = taken;
    res.npc         = (taken ? (pc_m + item.imm) : (pc_m + 16'd1)) & PC_MASK;
    res.sys_action  = act;
    res.sys_value   = sval;
    res.stop        = stop;
  end

endmodule
`default_nettype wire

// ===== hdl/mips_subset_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIPS subset execute - top level
// Executes one decoded instruction per transfer against the register file and
// reports the register write, branch outcome, next PC and syscall action.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  input    in         in_valid / in_stall    op, dest_reg, src_reg_a, src_reg_b,
//                                             immediate, current_pc
//  output   out        out_valid / out_stall  reg_written, written_index,
//                                             written_value, branch_taken, next_pc,
//                                             sys_action, sys_value, stop_request
//
// One instruction per cycle is accepted while the input is not stalled; a result passes
// through the register file read, then execute into the output register.
// The single register file write port and the result written back from the
// execute cycle are forwarded to the following instruction.
// Reset clears all register file entries through per-entry valid
// bits; no clearing pass is needed.
// A held output register stalls the execute stage, which, when it holds an
// instruction, stalls the input in the same cycle.
// ----------------------------------------------------------------------------
module mips_subset_execute (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  op,
  input  wire logic [4:0]  dest_reg,
  input  wire logic [4:0]  src_reg_a,
  input  wire logic [4:0]  src_reg_b,
  input  wire logic [15:0] immediate,
  input  wire logic [15:0] current_pc,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             reg_written,
  output logic [4:0]       written_index,
  output logic [31:0]      written_value,
  output logic             branch_taken,
  output logic [15:0]      next_pc,
  output logic [2:0]       sys_action,
  output logic [31:0]      sys_value,
  output logic             stop_request
);
  import mse_pkg::*;

  logic              accept;
  logic              s1_go;
  logic              s1_valid;
  item_t             s1_item;
  logic [REG_AW-1:0] s1_addr_a;
  logic [REG_AW-1:0] s1_addr_b;
  logic [REG_AW-1:0] rd_addr_a;
  logic [REG_AW-1:0] rd_addr_b;
  logic [DATA_W-1:0] rd_data_a;
  logic [DATA_W-1:0] rd_data_b;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  result_t           res;
  logic              wr_en;
  logic              wb_valid;
  logic [REG_AW-1:0] wb_idx;
  logic [DATA_W-1:0] wb_data;

  // Handshake: the execute stage moves on when the output register is free.
  assign s1_go    = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;

  // A syscall reads the call number and argument registers instead.
  assign rd_addr_a = (op == OP_SYSCALL) ? REG_V0 : src_reg_a;
  assign rd_addr_b = (op == OP_SYSCALL) ? REG_A0 : src_reg_b;

  // Register file write happens as the executed instruction leaves.
  assign wr_en = s1_valid && s1_go && res.reg_written;

  mse_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (res.windex),
    .wr_data   (res.wvalue)
  );

  // Read stage: hold the instruction fields while its operands are read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.op   <= op;
      s1_item.dest <= dest_reg;
      s1_item.imm  <= immediate;
      s1_item.pc   <= current_pc;
      s1_addr_a    <= rd_addr_a;
      s1_addr_b    <= rd_addr_b;
    end
  end

  // Last write, kept to cover a read issued in the same cycle as that write.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (wr_en) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_idx  <= res.windex;
      wb_data <= res.wvalue;
    end
  end

  // Operand forwarding from the last write.
  assign opa = (wb_valid && wb_idx == s1_addr_a) ? wb_data : rd_data_a;
  assign opb = (wb_valid && wb_idx == s1_addr_b) ? wb_data : rd_data_b;

  mse_alu u_alu (
    .item (s1_item),
    .opa  (opa),
    .opb  (opb),
    .res  (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go) begin
      reg_written   <= res.reg_written;
      written_index <= res.windex;
      written_value <= res.wvalue;
      branch_taken  <= res.taken;
      next_pc       <= res.npc;
      sys_action    <= res.sys_action;
      sys_value     <= res.sys_value;
      stop_request  <= res.stop;
    end
  end

  // An empty execute stage never holds off the input.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty execute stage");

  // Register zero is never written.
  a_no_zero_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (res.windex != '0))
    else $error("write to register zero");

  // An instruction leaving the execute stage shows up at the output.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_go) |=> out_valid)
    else $error("executed instruction lost");

  // The forwarding register captures every write.
  a_forward_capture: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (wb_valid && wb_idx == $past(res.windex) && wb_data == $past(res.wvalue)))
    else $error("forwarding register missed a write");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS subset execute - self-checking testbench
// Drives decoded instructions into the execute stage with random idle and
// stall cycles on both channels, keeps a shadow register file, works out the
// expected outcome of every instruction and compares each result transfer
// with it field by field.
// ----------------------------------------------------------------------------
import mse_pkg::*;

// Shadow of the execute stage: register file plus the queue of outcomes that
// accepted instructions are still owed.
class exec_shadow;
  logic [DATA_W-1:0] regs [NUM_REGS];
  result_t           owed_results [$];
  int unsigned       mismatches;

  function new();
    foreach (regs[i]) regs[i] = '0;
    mismatches = 0;
  endfunction

  // Executes one accepted instruction on the shadow state and queues its outcome.
  function void retire_instruction(logic [3:0] opc, logic [4:0] dst, logic [4:0] ra,
                                   logic [4:0] rb, logic [15:0] imm, logic [15:0] pc);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] simm;
    logic [DATA_W-1:0] val;
    logic              wr;
    logic              taken;
    result_t           r;

    a     = (ra == 5'd0) ? '0 : regs[ra];
    b     = (rb == 5'd0) ? '0 : regs[rb];
    simm  = {{16{imm[15]}}, imm};
    val   = '0;
    wr    = 1'b0;
    taken = 1'b0;
    r     = '0;

    case (opc)
      OP_ADD: begin
        wr  = 1'b1;
        val = a + b;
      end
      OP_SUB: begin
        wr  = 1'b1;
        val = a - b;
      end
      OP_SLT: begin
        wr  = 1'b1;
        val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      end
      OP_MUL: begin
        wr  = 1'b1;
        val = a * b;
      end
      OP_BEQ: taken = (a == b);
      OP_BNE: taken = (a != b);
      OP_ADDI: begin
        wr  = 1'b1;
        val = a + simm;
      end
      OP_ORI: begin
        wr  = 1'b1;
        val = a | {16'h0000, imm};
      end
      OP_LUI: begin
        wr  = 1'b1;
        val = {imm, 16'h0000};
      end
      OP_SYSCALL: begin
        // The call number lives in v0; print calls report a0, the rest v0.
        if (regs[REG_V0] == CALL_PRINT_INT) begin
          r.sys_action = SYS_PRINT_INT;
          r.sys_value  = regs[REG_A0];
        end else if (regs[REG_V0] == CALL_EXIT) begin
          r.sys_action = SYS_EXIT;
          r.sys_value  = regs[REG_V0];
          r.stop       = 1'b1;
        end else if (regs[REG_V0] == CALL_PRINT_CHAR) begin
          r.sys_action = SYS_PRINT_CHAR;
          r.sys_value  = regs[REG_A0];
        end else begin
          r.sys_action = SYS_UNKNOWN;
          r.sys_value  = regs[REG_V0];
          r.stop       = 1'b1;
        end
      end
      default: ;
    endcase

    // Branch target wraps at the PC width.
    r.taken = taken;
    r.npc   = (taken ? pc + imm : pc + 16'd1) & PC_MASK;

    // Writes to register zero are dropped.
    if (wr && dst != 5'd0) begin
      regs[dst]     = val;
      r.reg_written = 1'b1;
      r.windex      = dst;
      r.wvalue      = val;
    end
    owed_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Compares one result transfer with the oldest outcome still owed.
  function void check_result(result_t got);
    result_t want;
    if (owed_results.size() == 0) begin
      mismatches++;
      $error("result transfer arrived with no instruction outstanding");
      return;
    end
    want = owed_results.pop_front();
    compare_field("reg_written", want.reg_written, got.reg_written);
    compare_field("written_index", want.windex, got.windex);
    compare_field("written_value", want.wvalue, got.wvalue);
    compare_field("branch_taken", want.taken, got.taken);
    compare_field("next_pc", want.npc, got.npc);
    compare_field("sys_action", want.sys_action, got.sys_action);
    compare_field("sys_value", want.sys_value, got.sys_value);
    compare_field("stop_request", want.stop, got.stop);
  endfunction

  function int outstanding();
    return owed_results.size();
  endfunction
endclass

module tb_top;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          ITEMS_PER_PHASE = 170;
  localparam logic [3:0]  OP_FIRST_UNUSED = OP_SYSCALL + 4'd1;
  localparam logic [3:0]  OP_LAST_UNUSED  = 4'hF;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  op;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg_a;
  logic [4:0]  src_reg_b;
  logic [15:0] immediate;
  logic [15:0] current_pc;
  logic        out_valid;
  logic        out_stall;
  logic        reg_written;
  logic [4:0]  written_index;
  logic [31:0] written_value;
  logic        branch_taken;
  logic [15:0] next_pc;
  logic [2:0]  sys_action;
  logic [31:0] sys_value;
  logic        stop_request;

  exec_shadow  shadow;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned cycle_count;

  mips_subset_execute dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .dest_reg      (dest_reg),
    .src_reg_a     (src_reg_a),
    .src_reg_b     (src_reg_b),
    .immediate     (immediate),
    .current_pc    (current_pc),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reg_written   (reg_written),
    .written_index (written_index),
    .written_value (written_value),
    .branch_taken  (branch_taken),
    .next_pc       (next_pc),
    .sys_action    (sys_action),
    .sys_value     (sys_value),
    .stop_request  (stop_request)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      shadow.check_result(result_t'({reg_written, written_index, written_value, branch_taken,
                                     next_pc, sys_action, sys_value, stop_request}));
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Presents one instruction, after any idle cycles, and waits for its transfer.
  task automatic issue(input logic [3:0] i_op, input logic [4:0] i_dest,
                       input logic [4:0] i_ra, input logic [4:0] i_rb,
                       input logic [15:0] i_imm, input logic [15:0] i_pc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= i_op;
    dest_reg   <= i_dest;
    src_reg_a  <= i_ra;
    src_reg_b  <= i_rb;
    immediate  <= i_imm;
    current_pc <= i_pc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.retire_instruction(i_op, i_dest, i_ra, i_rb, i_imm, i_pc);
  endtask

  // Mostly the low registers, so that back-to-back dependencies are common.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int          sent;
    int          phase;
    logic [3:0]  rnd_op;
    logic [31:0] call_no;

    shadow         = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= OP_ADD;
    dest_reg   <= '0;
    src_reg_a  <= '0;
    src_reg_b  <= '0;
    immediate  <= '0;
    current_pc <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: operand extremes, every operation, register zero,
    // PC wrap in both directions, every syscall outcome and unused opcodes.
    send_idle_pct  = 36;
    recv_stall_pct = 69;
    issue(OP_ADD, 5'd1, 5'd0, 5'd0, 16'h0000, 16'h0000);
    issue(OP_ORI, 5'd1, 5'd0, 5'd0, 16'hFFFF, 16'h0001);
    issue(OP_LUI, 5'd3, 5'd0, 5'd0, 16'h8000, 16'h0002);
    issue(OP_ADDI, 5'd5, 5'd0, 5'd0, 16'hFFFF, 16'h0003);
    issue(OP_ADDI, 5'd6, 5'd3, 5'd0, 16'h8000, 16'h0004);
    issue(OP_ADDI, 5'd31, 5'd0, 5'd0, 16'h7FFF, 16'h0005);
    issue(OP_SUB, 5'd7, 5'd3, 5'd31, 16'h0000, 16'h0006);
    issue(OP_ADD, 5'd8, 5'd5, 5'd5, 16'h0000, 16'h0007);
    issue(OP_SLT, 5'd9, 5'd3, 5'd31, 16'h0000, 16'h0008);
    issue(OP_SLT, 5'd10, 5'd31, 5'd3, 16'h0000, 16'h0009);
    issue(OP_MUL, 5'd11, 5'd5, 5'd3, 16'h0000, 16'h000A);
    issue(OP_MUL, 5'd12, 5'd7, 5'd7, 16'h0000, 16'h000B);
    issue(OP_ADD, 5'd0, 5'd5, 5'd5, 16'h0000, 16'h000C);
    issue(OP_ORI, 5'd13, 5'd0, 5'd0, 16'h1234, 16'h000D);
    issue(OP_BEQ, 5'd0, 5'd0, 5'd0, 16'h8000, 16'h0000);
    issue(OP_BNE, 5'd0, 5'd5, 5'd31, 16'h7FFF, 16'hFFFF);
    issue(OP_BEQ, 5'd0, 5'd5, 5'd31, 16'h0010, 16'hFFFF);
    issue(OP_BNE, 5'd0, 5'd0, 5'd0, 16'h0010, 16'h0020);
    issue(OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'h0000, 16'h0021);
    issue(OP_ORI, REG_V0, 5'd0, 5'd0, 16'(CALL_PRINT_INT), 16'h0022);
    issue(OP_ADDI, REG_A0, 5'd0, 5'd0, 16'hFF85, 16'h0023);
    issue(OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'h0000, 16'h0024);
    issue(OP_ORI, REG_V0, 5'd0, 5'd0, 16'(CALL_PRINT_CHAR), 16'h0025);
    issue(OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'h0000, 16'h0026);
    issue(OP_ORI, REG_V0, 5'd0, 5'd0, 16'(CALL_EXIT), 16'h0027);
    issue(OP_SYSCALL, 5'd0, 5'd0, 5'd0, 16'h0000, 16'h0028);
    issue(OP_FIRST_UNUSED, 5'd14, 5'd5, 5'd5, 16'hFFFF, 16'hFFFF);
    issue(OP_LAST_UNUSED, 5'd15, 5'd5, 5'd5, 16'h8000, 16'h0029);

    // Random part in three phases of channel pressure.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 36;
          recv_stall_pct = 69;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 36;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          // Load a call number into v0, then make the call.
          case ($urandom_range(0, 3))
            0:       call_no = CALL_PRINT_INT;
            1:       call_no = CALL_PRINT_CHAR;
            2:       call_no = CALL_EXIT;
            default: call_no = 32'($urandom_range(0, 15));
          endcase
          issue(OP_ORI, REG_V0, 5'd0, 5'd0, call_no[15:0], 16'($urandom()));
          issue(OP_SYSCALL, pick_reg(), pick_reg(), pick_reg(), pick_imm(),
                16'($urandom()));
          sent += 2;
        end else begin
          if ($urandom_range(0, 99) < 6)
            rnd_op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
          else
            rnd_op = 4'($urandom_range(OP_ADD, OP_SYSCALL));
          issue(rnd_op, pick_reg(), pick_reg(), pick_reg(), pick_imm(), 16'($urandom()));
          sent++;
        end
      end
    end

    // Drain: wait for every owed result, then keep the clock running to catch strays.
    in_valid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mse_pkg.sv
hdl/mse_regfile.sv
hdl/mse_alu.sv
hdl/mips_subset_execute.sv
test/tb_top.sv
